// ===== sv/tfn_pkg.sv =====
`timescale 1ns / 1ps
package tfn_pkg;

  // magnitudes are brought down to this many bits before the root
  localparam int M_BITS   = 30;
  localparam int SQ_BITS  = 2 * M_BITS + 2;
  localparam int ROOT_BITS = M_BITS + 1;
  localparam int OUT_BITS = 16;
  localparam int OUT_MAX  = 32767;

  // per-item flags that ride along the pipeline
  typedef struct packed {
    logic [2:0] neg;
    logic       degen;
  } tfn_side_t;

endpackage

// ===== sv/tfn_cross.sv =====
`timescale 1ns / 1ps
module tfn_cross
  import tfn_pkg::*;
#(
  parameter int CW = 24,
  parameter int MW = 2 * CW + 3
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CW-1:0]        v1x, v1y, v1z,
  input  logic [CW-1:0]        v2x, v2y, v2z,
  input  logic [CW-1:0]        v3x, v3y, v3z,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [MW-1:0]        mag [3],
  output tfn_side_t            side
);

  localparam int EW = CW + 1;
  localparam int PW = 2 * EW;

  logic [3:0] vld;
  logic [4:0] go;

  // stall chain: a stage moves when it is empty or the next one moves
  always_comb begin
    go[4] = out_ready;
    for (int i = 0; i < 4; i++) go[i] = !vld[i] || go[i+1];
  end
  assign in_ready = go[0];
  assign out_valid = vld[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (go[0]) vld[0] <= in_valid;
      for (int i = 1; i < 4; i++) if (go[i]) vld[i] <= vld[i-1];
    end
  end

  // edges
  logic signed [EW-1:0] ax, ay, az, bx, by, bz;
  always_ff @(posedge clk) begin
    if (go[0]) begin
      ax <= $signed({v2x[CW-1], v2x}) - $signed({v1x[CW-1], v1x});
      ay <= $signed({v2y[CW-1], v2y}) - $signed({v1y[CW-1], v1y});
      az <= $signed({v2z[CW-1], v2z}) - $signed({v1z[CW-1], v1z});
      bx <= $signed({v3x[CW-1], v3x}) - $signed({v1x[CW-1], v1x});
      by <= $signed({v3y[CW-1], v3y}) - $signed({v1y[CW-1], v1y});
      bz <= $signed({v3z[CW-1], v3z}) - $signed({v1z[CW-1], v1z});
    end
  end

  // six partial products
  logic signed [PW-1:0] p0, p1, p2, p3, p4, p5;
  always_ff @(posedge clk) begin
    if (go[1]) begin
      p0 <= ay * bz;
      p1 <= az * by;
      p2 <= az * bx;
      p3 <= ax * bz;
      p4 <= ax * by;
      p5 <= ay * bx;
    end
  end

  // cross product components
  logic signed [MW-1:0] nx, ny, nz;
  always_ff @(posedge clk) begin
    if (go[2]) begin
      nx <= MW'(p0) - MW'(p1);
      ny <= MW'(p2) - MW'(p3);
      nz <= MW'(p4) - MW'(p5);
    end
  end

  // magnitudes, signs and zero test
  always_ff @(posedge clk) begin
    if (go[3]) begin
      mag[0] <= nx[MW-1] ? MW'(-nx) : MW'(nx);
      mag[1] <= ny[MW-1] ? MW'(-ny) : MW'(ny);
      mag[2] <= nz[MW-1] ? MW'(-nz) : MW'(nz);
      side.neg <= {nz[MW-1], ny[MW-1], nx[MW-1]};
      side.degen <= (nx == '0) && (ny == '0) && (nz == '0);
    end
  end

endmodule

// ===== sv/tfn_scale.sv =====
`timescale 1ns / 1ps
module tfn_scale
  import tfn_pkg::*;
#(
  parameter int MW = 51
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [MW-1:0]        mag [3],
  input  tfn_side_t            in_side,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [M_BITS-1:0]    m [3],
  output tfn_side_t            side,
  output logic [SQ_BITS-1:0]   sum
);

  localparam int LW = $clog2(MW + 1);
  localparam int XW = (MW > M_BITS) ? MW : M_BITS;

  logic [3:0] vld;
  logic [4:0] go;

  always_comb begin
    go[4] = out_ready;
    for (int i = 0; i < 4; i++) go[i] = !vld[i] || go[i+1];
  end
  assign in_ready = go[0];
  assign out_valid = vld[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (go[0]) vld[0] <= in_valid;
      for (int i = 1; i < 4; i++) if (go[i]) vld[i] <= vld[i-1];
    end
  end

  // bit length of the largest magnitude
  logic [MW-1:0] any_bits;
  logic [LW-1:0] len;
  always_comb begin
    any_bits = mag[0] | mag[1] | mag[2];
    len = '0;
    for (int i = 0; i < MW; i++) if (any_bits[i]) len = LW'(i + 1);
  end

  logic [XW-1:0] a_mag [3];
  logic [LW-1:0] a_sh;
  tfn_side_t     a_side;
  always_ff @(posedge clk) begin
    if (go[0]) begin
      for (int i = 0; i < 3; i++) a_mag[i] <= XW'(mag[i]);
      a_sh <= (len > LW'(M_BITS)) ? LW'(len - LW'(M_BITS)) : '0;
      a_side <= in_side;
    end
  end

  // bring magnitudes down to the working width
  logic [XW-1:0] shifted [3];
  always_comb begin
    for (int i = 0; i < 3; i++) shifted[i] = a_mag[i] >> a_sh;
  end

  logic [M_BITS-1:0] b_m [3];
  tfn_side_t         b_side;
  always_ff @(posedge clk) begin
    if (go[1]) begin
      for (int i = 0; i < 3; i++) b_m[i] <= shifted[i][M_BITS-1:0];
      b_side <= a_side;
    end
  end

  // squares
  logic [2*M_BITS-1:0] c_sq [3];
  logic [M_BITS-1:0]   c_m [3];
  tfn_side_t           c_side;
  always_ff @(posedge clk) begin
    if (go[2]) begin
      for (int i = 0; i < 3; i++) begin
        c_sq[i] <= b_m[i] * b_m[i];
        c_m[i] <= b_m[i];
      end
      c_side <= b_side;
    end
  end

  // sum of squares
  always_ff @(posedge clk) begin
    if (go[3]) begin
      sum <= SQ_BITS'(c_sq[0]) + SQ_BITS'(c_sq[1]) + SQ_BITS'(c_sq[2]);
      m <= c_m;
      side <= c_side;
    end
  end

endmodule

// ===== sv/tfn_isqrt.sv =====
`timescale 1ns / 1ps
module tfn_isqrt
  import tfn_pkg::*;
#(
  parameter int PW = 94
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [SQ_BITS-1:0]   sq,
  input  logic [PW-1:0]        in_pay,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [ROOT_BITS-1:0] root,
  output logic [PW-1:0]        pay
);

  localparam int RW = ROOT_BITS;
  localparam int SW = SQ_BITS;

  logic [RW-1:0] vld;
  logic [RW:0]   go;
  logic [SW-1:0] x_q [RW];
  logic [SW-1:0] r_q [RW];
  logic [PW-1:0] p_q [RW];

  always_comb begin
    go[RW] = out_ready;
    for (int i = 0; i < RW; i++) go[i] = !vld[i] || go[i+1];
  end
  assign in_ready = go[0];
  assign out_valid = vld[RW-1];
  assign root = r_q[RW-1][RW-1:0];
  assign pay = p_q[RW-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (go[0]) vld[0] <= in_valid;
      for (int i = 1; i < RW; i++) if (go[i]) vld[i] <= vld[i-1];
    end
  end

  // one root digit per stage, highest first
  for (genvar gi = 0; gi < RW; gi++) begin : g_step
    logic [SW-1:0] cur_x, cur_r, cur_b, trial;
    logic [PW-1:0] cur_p;
    if (gi == 0) begin : g_first
      assign cur_x = sq;
      assign cur_r = '0;
      assign cur_p = in_pay;
    end else begin : g_rest
      assign cur_x = x_q[gi-1];
      assign cur_r = r_q[gi-1];
      assign cur_p = p_q[gi-1];
    end
    assign cur_b = SW'(1) << (2 * (RW - 1 - gi));
    assign trial = cur_r + cur_b;

    always_ff @(posedge clk) begin
      if (go[gi]) begin
        if (cur_x >= trial) begin
          x_q[gi] <= cur_x - trial;
          r_q[gi] <= (cur_r >> 1) + cur_b;
        end else begin
          x_q[gi] <= cur_x;
          r_q[gi] <= cur_r >> 1;
        end
        p_q[gi] <= cur_p;
      end
    end
  end

endmodule

// ===== sv/tfn_div.sv =====
`timescale 1ns / 1ps
module tfn_div
  import tfn_pkg::*;
#(
  parameter int FB = 14
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [ROOT_BITS-1:0] root,
  input  logic [M_BITS-1:0]    m [3],
  input  tfn_side_t            in_side,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [FB:0]          quo [3],
  output tfn_side_t            side
);

  localparam int QW = FB + 1;
  localparam int DW = ROOT_BITS + FB + 1;

  logic [QW-1:0]        vld;
  logic [QW:0]          go;
  logic [DW-1:0]        rem_q [QW][3];
  logic [QW-1:0]        q_q   [QW][3];
  logic [ROOT_BITS-1:0] d_q   [QW];
  tfn_side_t            s_q   [QW];

  always_comb begin
    go[QW] = out_ready;
    for (int i = 0; i < QW; i++) go[i] = !vld[i] || go[i+1];
  end
  assign in_ready = go[0];
  assign out_valid = vld[QW-1];
  assign quo = q_q[QW-1];
  assign side = s_q[QW-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (go[0]) vld[0] <= in_valid;
      for (int i = 1; i < QW; i++) if (go[i]) vld[i] <= vld[i-1];
    end
  end

  // restoring division, one quotient bit per stage, rounded numerator
  for (genvar gi = 0; gi < QW; gi++) begin : g_step
    logic [DW-1:0]        cur_rem [3];
    logic [QW-1:0]        cur_q   [3];
    logic [ROOT_BITS-1:0] cur_d;
    tfn_side_t            cur_s;
    logic [DW-1:0]        dvs;
    if (gi == 0) begin : g_first
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          cur_rem[i] = (DW'(m[i]) << FB) + DW'(root >> 1);
          cur_q[i] = '0;
        end
      end
      assign cur_d = root;
      assign cur_s = in_side;
    end else begin : g_rest
      assign cur_rem = rem_q[gi-1];
      assign cur_q = q_q[gi-1];
      assign cur_d = d_q[gi-1];
      assign cur_s = s_q[gi-1];
    end
    assign dvs = DW'(cur_d) << (QW - 1 - gi);

    always_ff @(posedge clk) begin
      if (go[gi]) begin
        for (int i = 0; i < 3; i++) begin
          if (cur_rem[i] >= dvs) begin
            rem_q[gi][i] <= cur_rem[i] - dvs;
            q_q[gi][i] <= cur_q[i] | (QW'(1) << (QW - 1 - gi));
          end else begin
            rem_q[gi][i] <= cur_rem[i];
            q_q[gi][i] <= cur_q[i];
          end
        end
        d_q[gi] <= cur_d;
        s_q[gi] <= cur_s;
      end
    end
  end

endmodule

// ===== sv/triangle_face_normal.sv =====
`timescale 1ns / 1ps
// Unit normal of a triangle. Each transfer carries three vertices; the block
// forms both edges from the first vertex, their exact cross product, and
// scales it to unit length in signed Q1.(NORMAL_FRAC_BITS), rounding half
// away from zero and saturating at 1.0 (or 32767). A zero cross product
// gives a zero normal with degenerate set. Fully pipelined: one triangle is
// taken per cycle while the output is not stalled, and a result passes
// through the cross product, scaling, one-digit-per-stage square root and
// division pipelines, whose depth does not depend on COORD_WIDTH. Each
// stage holds its item during a stall and empty stages keep filling, so
// input transfers continue while a result waits, until the stages are full.
module triangle_face_normal
  import tfn_pkg::*;
#(
  parameter int COORD_WIDTH = 24,
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] first_x,
  input  logic signed [COORD_WIDTH-1:0] first_y,
  input  logic signed [COORD_WIDTH-1:0] first_z,
  input  logic signed [COORD_WIDTH-1:0] second_x,
  input  logic signed [COORD_WIDTH-1:0] second_y,
  input  logic signed [COORD_WIDTH-1:0] second_z,
  input  logic signed [COORD_WIDTH-1:0] third_x,
  input  logic signed [COORD_WIDTH-1:0] third_y,
  input  logic signed [COORD_WIDTH-1:0] third_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [OUT_BITS-1:0]    normal_x,
  output logic signed [OUT_BITS-1:0]    normal_y,
  output logic signed [OUT_BITS-1:0]    normal_z,
  output logic                          degenerate
);

  localparam int MW = 2 * COORD_WIDTH + 3;
  localparam int QW = NORMAL_FRAC_BITS + 1;
  localparam int LIM = (NORMAL_FRAC_BITS >= 15) ? OUT_MAX : (1 << NORMAL_FRAC_BITS);
  localparam int PW = 3 * M_BITS + $bits(tfn_side_t);

  // cross product
  logic          c_valid, c_ready;
  logic [MW-1:0] c_mag [3];
  tfn_side_t     c_side;

  tfn_cross #(.CW(COORD_WIDTH), .MW(MW)) u_cross (
    .clk, .rst,
    .in_valid, .in_ready,
    .v1x(first_x), .v1y(first_y), .v1z(first_z),
    .v2x(second_x), .v2y(second_y), .v2z(second_z),
    .v3x(third_x), .v3y(third_y), .v3z(third_z),
    .out_valid(c_valid), .out_ready(c_ready),
    .mag(c_mag), .side(c_side)
  );

  // scaling and sum of squares
  logic               s_valid, s_ready;
  logic [M_BITS-1:0]  s_m [3];
  tfn_side_t          s_side;
  logic [SQ_BITS-1:0] s_sum;

  tfn_scale #(.MW(MW)) u_scale (
    .clk, .rst,
    .in_valid(c_valid), .in_ready(c_ready),
    .mag(c_mag), .in_side(c_side),
    .out_valid(s_valid), .out_ready(s_ready),
    .m(s_m), .side(s_side), .sum(s_sum)
  );

  // square root, carrying magnitudes and flags
  logic                 r_valid, r_ready;
  logic [ROOT_BITS-1:0] r_root;
  logic [PW-1:0]        r_pay;
  logic [M_BITS-1:0]    r_m [3];
  tfn_side_t            r_side;

  tfn_isqrt #(.PW(PW)) u_isqrt (
    .clk, .rst,
    .in_valid(s_valid), .in_ready(s_ready),
    .sq(s_sum), .in_pay({s_m[2], s_m[1], s_m[0], s_side}),
    .out_valid(r_valid), .out_ready(r_ready),
    .root(r_root), .pay(r_pay)
  );

  assign {r_m[2], r_m[1], r_m[0], r_side} = r_pay;

  // division by the length
  logic          d_valid;
  logic [QW-1:0] d_quo [3];
  tfn_side_t     d_side;

  tfn_div #(.FB(NORMAL_FRAC_BITS)) u_div (
    .clk, .rst,
    .in_valid(r_valid), .in_ready(r_ready),
    .root(r_root), .m(r_m), .in_side(r_side),
    .out_valid(d_valid), .out_ready,
    .quo(d_quo), .side(d_side)
  );

  // saturate, apply sign, force zero on a degenerate triangle
  logic [QW-1:0]       sat [3];
  logic [OUT_BITS-1:0] res [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sat[i] = (d_quo[i] > QW'(LIM)) ? QW'(LIM) : d_quo[i];
      if (d_side.degen) begin
        res[i] = '0;
      end else if (d_side.neg[i]) begin
        res[i] = OUT_BITS'(0) - OUT_BITS'(sat[i]);
      end else begin
        res[i] = OUT_BITS'(sat[i]);
      end
    end
  end

  assign out_valid = d_valid;
  assign normal_x = res[0];
  assign normal_y = res[1];
  assign normal_z = res[2];
  assign degenerate = d_side.degen;

endmodule
